### sv/pco_pkg.sv
package pco_pkg;

	// Fixed widths of the cell fields, and limits and costs for words, patterns and results.
	localparam int GAIN_W      = 16;
	localparam int SCORE_W     = 37;
	localparam int NODE_W      = 5;
	localparam int POS_W       = 9;
	localparam int MAX_WORD_LEN = 256;
	localparam int PATTERN_COST = 4;
	localparam int RESULT_CAP  = 32;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_COVER = 1'b1;
	localparam logic KIND_UNCOVERED = 1'b0;
	localparam logic KIND_PATTERN   = 1'b1;

	typedef struct packed {
		logic        action;
		logic [7:0]  match_start;
		logic [8:0]  match_end;
		logic [31:0] match_score;
		logic [8:0]  word_length;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic [8:0] range_start;
		logic [8:0] range_end;
		logic [3:0] pat_idx;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [POS_W-1:0]         opt_pos;
		logic [POS_W-1:0]         cov_pos;
		logic signed [GAIN_W-1:0] gain;
		logic [SCORE_W-1:0]       score;
		logic [NODE_W-1:0]        node;
	} cell_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMPTY,
		ST_FILL,
		ST_READ,
		ST_EVAL,
		ST_PUSH,
		ST_WREAD,
		ST_WNODE,
		ST_WCHECK,
		ST_WGAP,
		ST_WPAT,
		ST_WTAIL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic fill;
		logic rd;
		logic eval;
		logic push;
		logic wnode;
		logic emit_empty;
		logic emit_gap;
		logic emit_pat;
		logic emit_tail;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic fill_done;
		logic eval_last;
		logic match_last;
		logic chain_ok;
		logic gap_needed;
		logic tail_needed;
		logic out_free;
	} stat_t;

endpackage

### sv/pco_ctrl.sv
module pco_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_action,
	output logic          req_stall,
	input  pco_pkg::stat_t st,
	output pco_pkg::cmd_t  cmd
);
	import pco_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req_action == ACT_COVER) begin
					state_d = st.count_zero ? ST_EMPTY : ST_FILL;
				end
			end
			ST_EMPTY: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			ST_FILL: begin
				if (st.fill_done) state_d = ST_READ;
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				state_d = st.eval_last ? ST_PUSH : ST_READ;
			end
			ST_PUSH: begin
				state_d = st.match_last ? ST_WREAD : ST_READ;
			end
			ST_WREAD: state_d = ST_WNODE;
			ST_WNODE: state_d = ST_WCHECK;
			ST_WCHECK: begin
				if (st.chain_ok) begin
					state_d = st.gap_needed ? ST_WGAP : ST_WPAT;
				end else if (st.tail_needed) begin
					state_d = ST_WTAIL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WGAP: begin
				if (st.out_free) state_d = ST_WPAT;
			end
			ST_WPAT: begin
				if (st.out_free) state_d = ST_WCHECK;
			end
			ST_WTAIL: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load  = accept && (req_action == ACT_LOAD);
				cmd.start = accept && (req_action == ACT_COVER);
			end
			ST_EMPTY: begin
				cmd.emit_empty = st.out_free;
				cmd.finish     = st.out_free;
			end
			ST_FILL:  cmd.fill = 1'b1;
			ST_READ:  cmd.rd = 1'b1;
			ST_EVAL:  cmd.eval = 1'b1;
			ST_PUSH:  cmd.push = 1'b1;
			ST_WREAD: cmd.rd = 1'b1;
			ST_WNODE: cmd.wnode = 1'b1;
			ST_WCHECK: begin
				cmd.finish = !st.chain_ok && !st.tail_needed;
			end
			ST_WGAP:  cmd.emit_gap = st.out_free;
			ST_WPAT:  cmd.emit_pat = st.out_free;
			ST_WTAIL: begin
				cmd.emit_tail = st.out_free;
				cmd.finish    = st.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

### sv/pco_datapath.sv
module pco_datapath #(
	parameter int MAX_MATCHES = 16,
	parameter int RING_DEPTH  = 272
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pco_pkg::req_t  req,
	input  pco_pkg::cmd_t  cmd,
	output pco_pkg::stat_t st,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pco_pkg::rsp_t  rsp
);
	import pco_pkg::*;

	localparam int CW = $clog2(MAX_MATCHES + 1);
	localparam int IW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
	localparam int NW = $clog2(MAX_MATCHES + 1);
	localparam int KW = $clog2(MAX_MATCHES + 2);
	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SW = $clog2(RING_DEPTH + 1);

	// Match store and control registers.
	logic [7:0]  ms_q [MAX_MATCHES];
	logic [8:0]  me_q [MAX_MATCHES];
	logic [31:0] sc_q [MAX_MATCHES];
	logic [CW-1:0] cnt_q;
	logic [8:0]    wl_q;
	logic [8:0]    p_q;
	logic [CW-1:0] i_q;
	logic [SW-1:0] e_q, size_q;
	logic [AW-1:0] head_q;
	logic          walk_q;

	// Best cell of the current scan.
	logic signed [GAIN_W-1:0] bgain_q;
	logic [SCORE_W-1:0]       bscore_q;
	logic [POS_W-1:0]         bcover_q;
	logic [NODE_W-1:0]        bnode_q;
	logic                     incl_q;

	// Chosen list.
	logic [IW-1:0] nm_q [MAX_MATCHES + 1];
	logic [NW-1:0] nn_q [MAX_MATCHES + 1];
	logic [KW-1:0] ncnt_q;
	logic [NW-1:0] nd_q;
	logic [8:0]    lu_q;
	logic [5:0]    n_q;

	// Cell ring memory.
	cell_t ring_q [RING_DEPTH];
	cell_t rd_q;
	cell_t wr_cell;
	logic  wr_en;
	logic [AW-1:0] wr_addr, rd_addr, head_dec;
	logic [AW:0]   addr_sum;

	// Match store read port.
	logic [IW-1:0] midx;
	logic [7:0]    cur_s;
	logic [8:0]    cur_e;
	logic [31:0]   cur_sc;

	assign midx   = walk_q ? nm_q[nd_q] : IW'(i_q - CW'(1));
	assign cur_s  = ms_q[midx];
	assign cur_e  = me_q[midx];
	assign cur_sc = sc_q[midx];

	assign addr_sum = {1'b0, head_q} + {1'b0, e_q[AW-1:0]};
	assign rd_addr  = (addr_sum >= (AW+1)'(RING_DEPTH)) ?
		AW'(addr_sum - (AW+1)'(RING_DEPTH)) : addr_sum[AW-1:0];
	assign head_dec = (head_q == '0) ? AW'(RING_DEPTH - 1) : head_q - AW'(1);

	// Candidate gain and score of the cell under evaluation.
	logic [8:0]               cov;
	logic signed [GAIN_W-1:0] g;
	logic [SCORE_W-1:0]       t;
	logic signed [GAIN_W-1:0] base_gain;
	logic [SCORE_W-1:0]       base_score;
	logic                     better, brk;

	always_comb begin
		cov = (rd_q.cov_pos >= cur_e) ? cur_e : rd_q.cov_pos;
		g = rd_q.gain - GAIN_W'(PATTERN_COST)
			+ $signed(GAIN_W'(cov)) - $signed(GAIN_W'(cur_s));
		t = rd_q.score + SCORE_W'(cur_sc);
		base_gain  = (e_q == '0) ? rd_q.gain  : bgain_q;
		base_score = (e_q == '0) ? rd_q.score : bscore_q;
		better = (g > base_gain) || ((g == base_gain) && (t > base_score));
		brk    = !better && (rd_q.opt_pos > cur_e);
	end

	logic take;
	assign take = incl_q && (ncnt_q <= KW'(MAX_MATCHES));

	// Ring write selection: initial fill or new front cell.
	always_comb begin
		wr_en   = cmd.fill || cmd.push;
		wr_addr = cmd.push ? head_dec : size_q[AW-1:0];
		wr_cell = '0;
		if (cmd.push) begin
			wr_cell.opt_pos = POS_W'(cur_s);
			wr_cell.cov_pos = take ? POS_W'(cur_s) : bcover_q;
			wr_cell.gain    = bgain_q;
			wr_cell.score   = bscore_q;
			wr_cell.node    = take ? NODE_W'(ncnt_q) : bnode_q;
		end else begin
			wr_cell.opt_pos = p_q + 9'd1;
			wr_cell.cov_pos = wl_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) ring_q[wr_addr] <= wr_cell;
		if (cmd.rd) rd_q <= ring_q[rd_addr];
	end

	// Chain walk lookahead.
	logic [NW-1:0] nxt;
	logic          nxt_ok, tail_after, pat_last;

	assign nxt        = nn_q[nd_q];
	assign nxt_ok     = (nxt != '0) && (KW'(nxt) < ncnt_q) &&
		((n_q + 6'd1) < 6'(RESULT_CAP));
	assign tail_after = wl_q > cur_e;
	assign pat_last   = !nxt_ok && !tail_after;

	// Status.
	always_comb begin
		st.count_zero  = (cnt_q == '0);
		st.fill_done   = ((p_q + 9'd1) == cur_e) || ((size_q + SW'(1)) == SW'(RING_DEPTH));
		st.eval_last   = brk || ((e_q + SW'(1)) == size_q);
		st.match_last  = (i_q == CW'(1));
		st.chain_ok    = (nd_q != '0) && (KW'(nd_q) < ncnt_q) && (n_q < 6'(RESULT_CAP));
		st.gap_needed  = 9'(cur_s) > lu_q;
		st.tail_needed = wl_q > lu_q;
		st.out_free    = !rsp_valid || !rsp_stall;
	end

	// Match loads and match count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.finish) begin
			cnt_q <= '0;
		end else if (cmd.load && (cnt_q < CW'(MAX_MATCHES)) &&
			(req.match_end > 9'(req.match_start)) &&
			(int'(req.match_end) <= MAX_WORD_LEN)) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < CW'(MAX_MATCHES))) begin
			ms_q[IW'(cnt_q)] <= req.match_start;
			me_q[IW'(cnt_q)] <= req.match_end;
			sc_q[IW'(cnt_q)] <= req.match_score;
		end
	end

	// Ring head and size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			size_q <= '0;
		end else if (cmd.start) begin
			head_q <= '0;
			size_q <= '0;
		end else if (cmd.fill) begin
			size_q <= size_q + SW'(1);
		end else if (cmd.eval && brk) begin
			size_q <= e_q;
		end else if (cmd.push) begin
			head_q <= head_dec;
			if (size_q < SW'(RING_DEPTH)) size_q <= size_q + SW'(1);
		end
	end

	// Program sequencing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= 1'b0;
			ncnt_q <= '0;
		end else if (cmd.start) begin
			walk_q <= 1'b0;
			ncnt_q <= KW'(1);
		end else if (cmd.wnode) begin
			walk_q <= 1'b1;
		end else if (cmd.push && take) begin
			ncnt_q <= ncnt_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			wl_q <= req.word_length;
			i_q  <= cnt_q;
			p_q  <= 9'(ms_q[IW'(cnt_q - CW'(1))]);
			e_q  <= '0;
			nm_q[0] <= '0;
			nn_q[0] <= '0;
		end
		if (cmd.fill) p_q <= p_q + 9'd1;
		if (cmd.eval) begin
			e_q <= e_q + SW'(1);
			if (better) begin
				bgain_q  <= g;
				bscore_q <= t;
				bcover_q <= rd_q.cov_pos;
				bnode_q  <= rd_q.node;
				incl_q   <= 1'b1;
			end else if (e_q == '0) begin
				bgain_q  <= rd_q.gain;
				bscore_q <= rd_q.score;
				bcover_q <= rd_q.cov_pos;
				bnode_q  <= rd_q.node;
				incl_q   <= 1'b0;
			end
		end
		if (cmd.push) begin
			e_q <= '0;
			i_q <= i_q - CW'(1);
			if (take) begin
				nm_q[NW'(ncnt_q)] <= IW'(i_q - CW'(1));
				nn_q[NW'(ncnt_q)] <= NW'(bnode_q);
			end
		end
		if (cmd.wnode) begin
			nd_q <= NW'(rd_q.node);
			lu_q <= '0;
			n_q  <= '0;
		end
		if (cmd.emit_gap) n_q <= n_q + 6'd1;
		if (cmd.emit_pat) begin
			n_q  <= n_q + 6'd1;
			lu_q <= cur_e;
			nd_q <= nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.emit_empty || cmd.emit_gap || cmd.emit_pat || cmd.emit_tail) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			rsp <= '{kind: KIND_UNCOVERED, range_start: 9'd0, range_end: wl_q,
				pat_idx: 4'd0, last: 1'b1};
		end else if (cmd.emit_gap) begin
			rsp <= '{kind: KIND_UNCOVERED, range_start: lu_q, range_end: 9'(cur_s),
				pat_idx: 4'd0, last: 1'b0};
		end else if (cmd.emit_pat) begin
			rsp <= '{kind: KIND_PATTERN, range_start: 9'(cur_s), range_end: cur_e,
				pat_idx: 4'(midx), last: pat_last};
		end else if (cmd.emit_tail) begin
			rsp <= '{kind: KIND_UNCOVERED, range_start: lu_q, range_end: wl_q,
				pat_idx: 4'd0, last: 1'b1};
		end
	end

endmodule

### sv/pattern_cover_optimizer_core.sv
// Loads are taken while idle; a cover with no matches emits a single uncovered result.
// A cover fills the ring with one cell per byte of the last match, then reads and
// evaluates each ring cell scanned and pushes one front cell per match; it then reads
// the front cell of the ring. The chain walk checks each chosen match, plus one final
// check, and emits each result; a stalled result holds the walk. One item at a time.
// Reset clears the match count, ring head and size, and the controller; stores stay unset.
module pattern_cover_optimizer_core #(
	parameter int MAX_MATCHES = 16,
	parameter int RING_DEPTH  = 272
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pco_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pco_pkg::rsp_t rsp
);
	import pco_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// Controller.
	pco_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.req_stall  (req_stall),
		.st         (st),
		.cmd        (cmd)
	);

	// Datapath with match store, cell ring and chosen list.
	pco_datapath #(
		.MAX_MATCHES (MAX_MATCHES),
		.RING_DEPTH  (RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import pco_pkg::*;

	localparam int NMATCH   = 16;
	localparam int NCELL    = 272;
	localparam int WDOG_MAX = 40000;

	// One row of the directed table: a request, and a typed-in result where one applies.
	typedef struct {
		req_t r;
		bit   typed;
		rsp_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	pattern_cover_optimizer_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Results still owed by the block, oldest first.
	rsp_t pending_q[$];
	row_t rows[$];
	int   mismatches;
	int   quiet_cycles;
	int   sent_items;
	bit   calm;
	bit   hold_req;

	// Shadow of the match store and of the cell ring.
	int              sh_start[NMATCH];
	int              sh_end[NMATCH];
	longint unsigned sh_score[NMATCH];
	int              sh_count;
	int              c_opt[NCELL];
	int              c_cov[NCELL];
	int              c_gain[NCELL];
	longint unsigned c_score[NCELL];
	int              c_node[NCELL];
	int              r_head;
	int              r_size;
	int              n_match[NMATCH + 1];
	int              n_next[NMATCH + 1];
	int              n_count;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void queue_rsp(input rsp_t x);
		pending_q.insert(pending_q.size(), x);
	endfunction

	function automatic void add_row(input req_t r, input bit typed, input rsp_t res);
		row_t nr;
		nr.r = r;
		nr.typed = typed;
		nr.res = res;
		rows.insert(rows.size(), nr);
	endfunction

	// Work out the cover of one word and queue the result list it gives.
	task automatic predict_cover(input int wl);
		rsp_t            outs[$];
		rsp_t            one;
		int              ls, le, s, ep, g, nd, mi, last_unc, ix;
		int              bgain, bcov, bnode;
		longint unsigned bscore, t;
		bit              incl;
		if (sh_count == 0) begin
			queue_rsp('{KIND_UNCOVERED, 9'd0, wl[8:0], 4'd0, 1'b1});
			return;
		end
		r_head = 0;
		r_size = 0;
		n_match[0] = 0;
		n_next[0] = 0;
		n_count = 1;
		ls = sh_start[sh_count - 1];
		le = sh_end[sh_count - 1];
		for (int p = ls; p < le && r_size < NCELL; p++) begin
			c_opt[r_size] = p + 1;
			c_cov[r_size] = wl;
			c_gain[r_size] = 0;
			c_score[r_size] = 0;
			c_node[r_size] = 0;
			r_size++;
		end
		for (int i = sh_count; i > 0; i--) begin
			s = sh_start[i - 1];
			ep = sh_end[i - 1];
			bgain = c_gain[r_head];
			bscore = c_score[r_head];
			bcov = c_cov[r_head];
			bnode = c_node[r_head];
			incl = 0;
			for (int e = 0; e < r_size; e++) begin
				ix = (r_head + e) % NCELL;
				g = c_gain[ix] - PATTERN_COST;
				t = c_score[ix] + sh_score[i - 1];
				if (c_cov[ix] >= ep)
					g += ep - s;
				else
					g += c_cov[ix] - s;
				if (g > bgain || (g == bgain && t > bscore)) begin
					bgain = g;
					bscore = t;
					incl = 1;
					bcov = c_cov[ix];
					bnode = c_node[ix];
				end else if (c_opt[ix] > ep) begin
					r_size = e;
					break;
				end
			end
			r_head = (r_head + NCELL - 1) % NCELL;
			c_opt[r_head] = s;
			c_gain[r_head] = bgain;
			c_score[r_head] = bscore;
			if (incl && n_count <= NMATCH) begin
				c_cov[r_head] = s;
				c_node[r_head] = n_count;
				n_match[n_count] = i - 1;
				n_next[n_count] = bnode;
				n_count++;
			end else begin
				c_cov[r_head] = bcov;
				c_node[r_head] = bnode;
			end
			if (r_size < NCELL)
				r_size++;
		end
		// Walk the chosen chain from the front cell.
		nd = c_node[r_head];
		last_unc = 0;
		while (nd != 0 && nd < n_count && outs.size() < RESULT_CAP) begin
			mi = n_match[nd] % NMATCH;
			if (sh_start[mi] > last_unc) begin
				one = '{KIND_UNCOVERED, last_unc[8:0], 9'(sh_start[mi]), 4'd0, 1'b0};
				outs.insert(outs.size(), one);
			end
			last_unc = sh_end[mi];
			one = '{KIND_PATTERN, 9'(sh_start[mi]), 9'(sh_end[mi]), 4'(mi), 1'b0};
			outs.insert(outs.size(), one);
			nd = n_next[nd];
		end
		if (wl > last_unc) begin
			one = '{KIND_UNCOVERED, last_unc[8:0], wl[8:0], 4'd0, 1'b0};
			outs.insert(outs.size(), one);
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[k])
			queue_rsp(outs[k]);
		sh_count = 0;
	endtask

	// Apply one accepted request to the shadow state.
	task automatic track_request(input req_t r);
		if (r.action == ACT_LOAD) begin
			if (sh_count < NMATCH && r.match_end > r.match_start &&
				r.match_end <= MAX_WORD_LEN) begin
				sh_start[sh_count] = r.match_start;
				sh_end[sh_count] = r.match_end;
				sh_score[sh_count] = r.match_score;
				sh_count++;
			end
		end else begin
			predict_cover(r.word_length);
		end
	endtask

	// Offer one request and hold it until the block takes it.
	task automatic send(input req_t r, input bit typed, input rsp_t res);
		if (!calm && $urandom_range(0, 99) < 17) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_items++;
		if (typed)
			queue_rsp(res);
		else
			track_request(r);
	endtask

	function automatic req_t load_req(input int s, input int e, input logic [31:0] sc);
		req_t r;
		r = '0;
		r.action = ACT_LOAD;
		r.match_start = s[7:0];
		r.match_end = e[8:0];
		r.match_score = sc;
		return r;
	endfunction

	function automatic req_t cover_req(input int wl);
		req_t r;
		r = '0;
		r.action = ACT_COVER;
		r.word_length = wl[8:0];
		r.match_start = 8'($urandom);
		return r;
	endfunction

	// One random word: mostly sorted, valid matches, with some noise mixed in.
	task automatic random_word();
		int   n, s, e, wl, last_end, base;
		logic [31:0] sc;
		req_t r;
		n = $urandom_range(0, 16);
		if ($urandom_range(0, 7) == 0)
			n = $urandom_range(17, 19);
		base = ($urandom_range(0, 5) == 0) ? $urandom_range(150, 250) : $urandom_range(0, 20);
		s = base;
		last_end = 0;
		for (int k = 0; k < n; k++) begin
			s = s + $urandom_range(0, 6);
			if (s > 255)
				s = 255;
			e = s + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8));
			if (e > 256)
				e = 256;
			sc = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
			case ($urandom_range(0, 19))
				0: r = load_req(s, $urandom_range(0, s), sc);
				1: r = load_req(s, $urandom_range(257, 511), sc);
				2: r = load_req($urandom_range(0, 255), e, sc);
				default: r = load_req(s, e, sc);
			endcase
			if (r.match_end > r.match_start && r.match_end <= 256)
				last_end = r.match_end;
			send(r, 1'b0, '0);
		end
		if ($urandom_range(0, 9) < 7) begin
			wl = last_end + $urandom_range(0, 10);
			if (wl > 256)
				wl = 256;
		end else begin
			wl = $urandom_range(0, 256);
		end
		send(cover_req(wl), 1'b0, '0);
	endtask

	// Receiver: random stalls, or a long hold-off when asked.
	initial begin
		forever begin
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else begin
				rsp_stall <= (!calm && $urandom_range(0, 99) < 17);
				@(posedge clk);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind=%0d start=%0d end=%0d idx=%0d last=%0d",
						rsp.kind, rsp.range_start, rsp.range_end, rsp.pat_idx, rsp.last);
			end else begin
				if (rsp !== pending_q[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp kind=%0d start=%0d end=%0d idx=%0d last=%0d",
							pending_q[0].kind, pending_q[0].range_start,
							pending_q[0].range_end, pending_q[0].pat_idx, pending_q[0].last);
						$display("          got kind=%0d start=%0d end=%0d idx=%0d last=%0d",
							rsp.kind, rsp.range_start, rsp.range_end, rsp.pat_idx, rsp.last);
					end
				end
				void'(pending_q.pop_front());
			end
		end
	end

	// Watchdog on cycles with no request or result accepted.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WDOG_MAX) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int words;
		mismatches = 0;
		quiet_cycles = 0;
		sent_items = 0;
		calm = 0;
		hold_req = 0;
		sh_count = 0;
		arst_n = 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		// Directed table.
		add_row(cover_req(0), 1'b1, '{KIND_UNCOVERED, 9'd0, 9'd0, 4'd0, 1'b1});
		add_row(cover_req(256), 1'b1, '{KIND_UNCOVERED, 9'd0, 9'd256, 4'd0, 1'b1});
		add_row(load_req(5, 5, 32'd1), 1'b0, '0);
		add_row(load_req(10, 300, 32'd1), 1'b0, '0);
		add_row(cover_req(8), 1'b1, '{KIND_UNCOVERED, 9'd0, 9'd8, 4'd0, 1'b1});
		add_row(load_req(0, 256, 32'hFFFF_FFFF), 1'b0, '0);
		add_row(cover_req(256), 1'b0, '0);
		add_row(load_req(255, 256, 32'h0), 1'b0, '0);
		add_row(cover_req(256), 1'b0, '0);
		add_row(load_req(2, 20, 32'h8000_0000), 1'b0, '0);
		add_row(cover_req(10), 1'b0, '0);
		add_row(load_req(0, 1, 32'h0), 1'b0, '0);
		add_row(cover_req(0), 1'b0, '0);
		add_row(load_req(10, 14, 32'h7), 1'b0, '0);
		add_row(load_req(0, 12, 32'h3), 1'b0, '0);
		add_row(cover_req(16), 1'b0, '0);
		add_row(load_req(0, 8, 32'h5), 1'b0, '0);
		add_row(load_req(0, 8, 32'h9), 1'b0, '0);
		add_row(cover_req(8), 1'b0, '0);
		add_row(load_req(1, 6, 32'h1), 1'b0, '0);
		add_row(load_req(12, 20, 32'h2), 1'b0, '0);
		add_row(cover_req(30), 1'b0, '0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[k])
			send(rows[k].r, rows[k].typed, rows[k].res);
		// Random words.
		words = 0;
		while (sent_items < 180) begin
			calm = (words >= 4 && words < 8);
			if (words == 2)
				hold_req = 1;
			if (words == 9) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending_q.size() != 0)
					@(posedge clk);
			end
			random_word();
			words++;
		end
		req_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
